// File: design/bal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array list package
// Shared widths, defaults, request codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package bal_pkg;

   localparam int DEPTH_DEFAULT         = 16;
   localparam int ELEMENT_WIDTH_DEFAULT = 32;

   localparam int REQ_TYPE_W = 2;
   localparam int INDEX_W    = 4;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;
   localparam int CAP_W      = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_APPEND = 2'd0,
      OP_SET    = 2'd1,
      OP_GET    = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_GET   = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage
`default_nettype wire

// File: design/bal_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array list channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
interface bal_req_if import bal_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [INDEX_W-1:0]    index;
   logic [VALUE_W-1:0]    value;

   modport source (output valid, req_type, index, value, input ready);
   modport sink   (input valid, req_type, index, value, output ready);
endinterface

interface bal_rsp_if import bal_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  read_value;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, read_value, status, count, input ready);
   modport sink   (input valid, read_value, status, count, output ready);
endinterface
`default_nettype wire

// File: design/bal_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array list element store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bal_mem import bal_pkg::*; #(
   parameter int DEPTH         = DEPTH_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT,
   localparam int ADDR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [ELEMENT_WIDTH-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output      logic [ELEMENT_WIDTH-1:0] rd_data
);

   logic [ELEMENT_WIDTH-1:0] mem_ff [DEPTH];
   logic [ELEMENT_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: design/bounded_array_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array list
// Dense list of up to DEPTH elements with append, set, get and remove.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request (req_type, index, value) under valid/ready.
//   rsp_chan returns exactly one response per request, in order: read_value
//   (element for a good get, zero otherwise), status and the new count.
//   csr_we/csr_wdata write the capacity limit; write only while idle.
// Timing:
//   The element store has one write and one read port; a sequencer drives
//   both. Append, set and any failed request go from idle straight to the
//   done state, get passes through a read state first; the done state loads
//   the output register. Remove moves one element per cycle through the store.
//   The next request is taken once the sequencer is back in idle, which it
//   enters as the response is loaded: one request at a time, no overlap.
// Reset:
//   Clears the count to zero, sets the capacity limit to 16, drops any
//   pending response. Element contents are not cleared.
// Stall:
//   A finished result waits in the sequencer while the output register is
//   still held by the receiver; no further request is taken meanwhile.
// ----------------------------------------------------------------------------
module bounded_array_list import bal_pkg::*; #(
   parameter int DEPTH         = DEPTH_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   bal_req_if.sink               req_chan,
   bal_rsp_if.source             rsp_chan,
   input  wire logic             csr_we,
   input  wire logic [CAP_W-1:0] csr_wdata
);

   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_W   = $clog2(DEPTH + 1);
   // common width for index and length compares
   localparam int CMP_W   = (LEN_W > INDEX_W) ? LEN_W : INDEX_W;
   // common width for capacity compares
   localparam int CAPC_W  = (LEN_W > CAP_W) ? LEN_W : CAP_W;
   localparam int PTR_C_W = LEN_W + 1;

   // Sequencer and working registers
   state_type             state_ff, state_in;
   logic [LEN_W-1:0]      length_ff, length_in;
   logic [CAP_W-1:0]      cap_ff, cap_in;
   logic [ADDR_W-1:0]     ptr_ff, ptr_in;
   logic [VALUE_W-1:0]    rd_ff, rd_in;
   status_type            status_ff, status_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   // Element store ports
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr;
   logic [ELEMENT_WIDTH-1:0] mem_wdata;
   logic [ADDR_W-1:0]        mem_raddr;
   logic [ELEMENT_WIDTH-1:0] mem_rdata;

   // Decode
   logic                  accept;
   logic                  rsp_free;
   op_type                op;
   logic [CMP_W-1:0]      idx_cmp;
   logic [CMP_W-1:0]      len_cmp;
   logic [ADDR_W-1:0]     idx_addr;
   logic [CAPC_W-1:0]     cap_eff;
   logic                  list_full;
   logic                  in_range;
   logic [PTR_C_W-1:0]    ptr_next2;
   logic [PTR_C_W-1:0]    idx_next1;

   bal_mem #(
      .DEPTH         (DEPTH),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign op        = op_type'(req_chan.req_type);
   assign idx_cmp   = CMP_W'(req_chan.index);
   assign len_cmp   = CMP_W'(length_ff);
   assign in_range  = idx_cmp < len_cmp;
   assign idx_addr  = idx_cmp[ADDR_W-1:0];
   // saturate the limit at the store depth
   assign cap_eff   = (CAPC_W'(cap_ff) > CAPC_W'(DEPTH)) ? CAPC_W'(DEPTH) : CAPC_W'(cap_ff);
   assign list_full = CAPC_W'(length_ff) >= cap_eff;
   assign idx_next1 = PTR_C_W'(idx_cmp[ADDR_W-1:0]) + PTR_C_W'(1);
   assign ptr_next2 = PTR_C_W'(ptr_ff) + PTR_C_W'(2);

   always_comb begin
      state_in      = state_ff;
      length_in     = length_ff;
      cap_in        = csr_we ? csr_wdata : cap_ff;
      ptr_in        = ptr_ff;
      rd_in         = rd_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_addr;
      mem_wdata     = ELEMENT_WIDTH'(req_chan.value);
      mem_raddr     = idx_addr;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_in     = '0;
               status_in = STAT_OK;
               state_in  = ST_DONE;
               if (op == OP_APPEND) begin
                  if (list_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = length_ff[ADDR_W-1:0];
                     length_in = LEN_W'(length_ff + 1'b1);
                  end
               end else if (!in_range) begin
                  status_in = STAT_RANGE;
               end else if (op == OP_SET) begin
                  mem_we = 1'b1;
               end else if (op == OP_GET) begin
                  state_in = ST_GET;
               end else begin
                  // remove: walk later elements down one place at a time
                  ptr_in = idx_addr;
                  if (idx_next1 < PTR_C_W'(length_ff)) begin
                     mem_raddr = ADDR_W'(idx_next1);
                     state_in  = ST_SHIFT;
                  end else begin
                     length_in = LEN_W'(length_ff - 1'b1);
                  end
               end
            end
         end

         ST_GET: begin
            rd_in    = VALUE_W'(mem_rdata);
            state_in = ST_DONE;
         end

         ST_SHIFT: begin
            // mem_rdata holds element ptr+1; drop it into ptr
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = mem_rdata;
            ptr_in    = ADDR_W'(PTR_C_W'(ptr_ff) + PTR_C_W'(1));
            if (ptr_next2 < PTR_C_W'(length_ff)) begin
               mem_raddr = ADDR_W'(ptr_next2);
            end else begin
               length_in = LEN_W'(length_ff - 1'b1);
               state_in  = ST_DONE;
            end
         end

         ST_DONE: begin
            // hold the result until the output register frees up
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_W'(length_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      rd_ff         <= rd_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.count      = rsp_count_ff;

endmodule
`default_nettype wire

// File: sim/tb_bounded_array_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded array list testbench
// Sends append, set, get and remove requests through the request channel
// and scores every response against a cycle-free list predictor kept in the
// bench. A short table of directed requests runs first and covers empty-list
// errors, full-list errors, capacity changes and shifting removes. Random
// phases follow, each under its own capacity limit. Both channels idle in
// random bursts, and one long response hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_bounded_array_list;
   import bal_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int LIST_DEPTH    = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int QUIET_TAIL    = 200;   // final random requests with no idling
   localparam int SETTLE_CYCLES = 24;    // settle time before a capacity write
   localparam int STALL_LIMIT   = 1000;  // cycles with no handshake at all
   localparam int LONG_HOLD     = 120;   // one long response hold-off
   localparam int HOLD_TRIGGER  = 300;   // responses seen before that hold-off
   localparam int MAX_REPORTS   = 10;

   // One response as the block returns it.
   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } list_result;

   // One row of the directed table: either a capacity write or a request,
   // with a hand-written response where it is obvious.
   typedef struct {
      bit                 is_cfg;
      logic [CAP_W-1:0]   cap;
      op_type             op;
      logic [INDEX_W-1:0] idx;
      logic [VALUE_W-1:0] val;
      bit                 typed;
      list_result         want;
   } directed_row;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [CAP_W-1:0] csr_wdata;

   bal_req_if req_chan ();
   bal_rsp_if rsp_chan ();

   bounded_array_list uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Predicted list contents, length and capacity register.
   logic [VALUE_W-1:0] list_cells [LIST_DEPTH];
   int                 list_len;
   logic [CAP_W-1:0]   cap_limit;

   list_result  pending_results [$];
   directed_row directed_rows [$];

   int  error_count;
   int  requests_sent;
   int  results_seen;
   int  ok_seen;
   int  full_seen;
   int  range_seen;
   int  deepest_list;
   int  cap_writes;
   int  stall_cycles;
   bit  quiet_tail;
   bit  req_calm;
   bit  rsp_calm;

   always #(HALF_PERIOD) clock = ~clock;

   // Apply one request to the predicted list and return the response it
   // should produce.
   function automatic list_result predict_list_op(input op_type op,
                                                  input logic [INDEX_W-1:0] idx,
                                                  input logic [VALUE_W-1:0] val);
      list_result r;
      int         eff_cap;
      int         i;
      r.read_value = '0;
      r.status     = STAT_OK;
      // Capacity above the list depth saturates at the depth.
      eff_cap = (int'(cap_limit) > LIST_DEPTH) ? LIST_DEPTH : int'(cap_limit);
      if (op == OP_APPEND) begin
         // A limit lowered below the length also refuses appends.
         if (list_len >= eff_cap) begin
            r.status = STAT_FULL;
         end else begin
            list_cells[list_len] = val;
            list_len++;
         end
      end else if (int'(idx) >= list_len) begin
         r.status = STAT_RANGE;
      end else begin
         case (op)
            OP_SET: begin
               list_cells[idx] = val;
            end
            OP_GET: begin
               r.read_value = list_cells[idx];
            end
            default: begin
               // Close the gap and clear the cell that leaves the list.
               for (i = int'(idx); i + 1 < list_len; i++) begin
                  list_cells[i] = list_cells[i + 1];
               end
               list_cells[list_len - 1] = '0;
               list_len--;
            end
         endcase
      end
      r.count = list_len[COUNT_W-1:0];
      if (list_len > deepest_list) begin
         deepest_list = list_len;
      end
      return r;
   endfunction

   // Empty table row: a plain append with nothing typed in.
   function automatic directed_row blank_row();
      directed_row row;
      row.is_cfg = 1'b0;
      row.cap    = '0;
      row.op     = OP_APPEND;
      row.idx    = '0;
      row.val    = '0;
      row.typed  = 1'b0;
      row.want   = '{read_value: '0, status: STAT_OK, count: '0};
      return row;
   endfunction

   function automatic void add_cfg_row(input logic [CAP_W-1:0] cap);
      directed_row row;
      row = blank_row();
      row.is_cfg = 1'b1;
      row.cap    = cap;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_req_row(input op_type op, input logic [INDEX_W-1:0] idx,
                                       input logic [VALUE_W-1:0] val);
      directed_row row;
      row = blank_row();
      row.op  = op;
      row.idx = idx;
      row.val = val;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_typed_row(input op_type op, input logic [INDEX_W-1:0] idx,
                                         input logic [VALUE_W-1:0] val,
                                         input logic [VALUE_W-1:0] rd,
                                         input status_type st,
                                         input logic [COUNT_W-1:0] cnt);
      directed_row row;
      row = blank_row();
      row.op    = op;
      row.idx   = idx;
      row.val   = val;
      row.typed = 1'b1;
      row.want  = '{read_value: rd, status: st, count: cnt};
      directed_rows.push_back(row);
   endfunction

   // Offer one request, hold it until the block takes it, then record the
   // response it must produce. Valid stays high when requests follow back
   // to back.
   task automatic send_request(input op_type op, input logic [INDEX_W-1:0] idx,
                               input logic [VALUE_W-1:0] val, input bit typed,
                               input list_result want);
      list_result predicted;
      int         gap;
      if (!quiet_tail && !req_calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= op;
      req_chan.index    <= idx;
      req_chan.value    <= val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = predict_list_op(op, idx, val);
      pending_results.push_back(typed ? want : predicted);
      requests_sent++;
   endtask

   // Drain every outstanding response, let the block settle, then write
   // the capacity limit.
   task automatic drain_and_set_cap(input logic [CAP_W-1:0] cap);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we    <= 1'b0;
      cap_limit = cap;
      cap_writes++;
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%s", msg);
      end
   endtask

   // Stimulus: directed table, then random phases, then the verdict.
   initial begin
      directed_row        row;
      list_result         none;
      op_type             op;
      logic [INDEX_W-1:0] idx;
      logic [VALUE_W-1:0] val;
      logic [CAP_W-1:0]   cap;
      int                 random_sent;
      int                 phase_items;
      int                 bias;
      int                 roll;
      int                 k;

      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_wdata         <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.req_type <= OP_APPEND;
      req_chan.index    <= '0;
      req_chan.value    <= '0;
      none        = '{read_value: '0, status: STAT_OK, count: '0};
      random_sent = 0;
      list_len    = 0;
      cap_limit   = CAP_RESET;
      for (k = 0; k < LIST_DEPTH; k++) begin
         list_cells[k] = '0;
      end

      // Empty list: every indexed request is out of range.
      add_typed_row(OP_GET,    4'd0,  32'h0000_0000, 32'h0, STAT_RANGE, 5'd0);
      add_typed_row(OP_SET,    4'd15, 32'hFFFF_FFFF, 32'h0, STAT_RANGE, 5'd0);
      add_typed_row(OP_REMOVE, 4'd0,  32'h0000_0000, 32'h0, STAT_RANGE, 5'd0);
      // Extreme values in and out.
      add_typed_row(OP_APPEND, 4'd0,  32'hFFFF_FFFF, 32'h0, STAT_OK, 5'd1);
      add_typed_row(OP_APPEND, 4'd15, 32'h0000_0000, 32'h0, STAT_OK, 5'd2);
      add_typed_row(OP_GET,    4'd0,  32'h0000_0000, 32'hFFFF_FFFF, STAT_OK, 5'd2);
      add_typed_row(OP_SET,    4'd1,  32'hA5A5_A5A5, 32'h0, STAT_OK, 5'd2);
      add_req_row  (OP_GET,    4'd1,  32'h0000_0000);
      add_typed_row(OP_GET,    4'd2,  32'h0000_0000, 32'h0, STAT_RANGE, 5'd2);
      // Limit reached exactly.
      add_cfg_row(5'd2);
      add_typed_row(OP_APPEND, 4'd0,  32'h1234_5678, 32'h0, STAT_FULL, 5'd2);
      // Limit lowered below the length: indexed requests still work.
      add_cfg_row(5'd1);
      add_req_row  (OP_SET,    4'd0,  32'h5A5A_5A5A);
      add_req_row  (OP_GET,    4'd0,  32'h0000_0000);
      add_typed_row(OP_REMOVE, 4'd1,  32'h0000_0000, 32'h0, STAT_OK, 5'd1);
      add_typed_row(OP_APPEND, 4'd0,  32'h8765_4321, 32'h0, STAT_FULL, 5'd1);
      // Zero limit: appends always fail.
      add_cfg_row(5'd0);
      add_typed_row(OP_APPEND, 4'd0,  32'hDEAD_BEEF, 32'h0, STAT_FULL, 5'd1);
      add_typed_row(OP_REMOVE, 4'd0,  32'h0000_0000, 32'h0, STAT_OK, 5'd0);
      add_typed_row(OP_APPEND, 4'd0,  32'hDEAD_BEEF, 32'h0, STAT_FULL, 5'd0);
      add_typed_row(OP_GET,    4'd0,  32'h0000_0000, 32'h0, STAT_RANGE, 5'd0);
      // Limit above the depth, then a shifting remove from the front.
      add_cfg_row(5'd31);
      add_req_row  (OP_APPEND, 4'd0,  32'h0000_FFFF);
      add_req_row  (OP_APPEND, 4'd0,  32'hFFFF_0000);
      add_req_row  (OP_APPEND, 4'd0,  32'h1357_9BDF);
      add_req_row  (OP_REMOVE, 4'd0,  32'h0000_0000);
      add_req_row  (OP_GET,    4'd0,  32'h0000_0000);
      add_req_row  (OP_GET,    4'd1,  32'h0000_0000);
      add_typed_row(OP_SET,    4'd15, 32'hFFFF_FFFF, 32'h0, STAT_RANGE, 5'd2);

      // Hold reset at the start, then release it for good.
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.is_cfg) begin
            drain_and_set_cap(row.cap);
         end else begin
            send_request(row.op, row.idx, row.val, row.typed, row.want);
         end
      end

      // Random phases: each picks a capacity, an idling mood and a bias that
      // either fills the list, drains it or mixes both.
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0:       cap = 5'd0;
            1:       cap = 5'd1;
            2:       cap = 5'd16;
            3:       cap = 5'd31;
            4:       cap = 5'($urandom_range(17, 31));
            default: cap = 5'($urandom_range(1, 16));
         endcase
         drain_and_set_cap(cap);
         req_calm    = ($urandom_range(0, 3) == 0);
         rsp_calm    = ($urandom_range(0, 3) == 0);
         bias        = $urandom_range(0, 2);
         phase_items = $urandom_range(40, 150);
         for (k = 0; k < phase_items && random_sent < RANDOM_ITEMS; k++) begin
            if (random_sent >= RANDOM_ITEMS - QUIET_TAIL) begin
               quiet_tail = 1'b1;
            end
            roll = $urandom_range(0, 99);
            case (bias)
               0: op = (roll < 55) ? OP_APPEND : (roll < 70) ? OP_SET :
                       (roll < 85) ? OP_GET : OP_REMOVE;
               1: op = (roll < 15) ? OP_APPEND : (roll < 35) ? OP_SET :
                       (roll < 55) ? OP_GET : OP_REMOVE;
               default: op = (roll < 30) ? OP_APPEND : (roll < 55) ? OP_SET :
                             (roll < 80) ? OP_GET : OP_REMOVE;
            endcase
            // Mostly live positions; now and then any index, which may miss.
            if (list_len > 0 && $urandom_range(0, 9) != 0) begin
               idx = 4'($urandom_range(0, list_len - 1));
            end else begin
               idx = 4'($urandom_range(0, 15));
            end
            case ($urandom_range(0, 15))
               0:       val = '0;
               1:       val = '1;
               default: val = $urandom;
            endcase
            send_request(op, idx, val, 1'b0, none);
            random_sent++;
         end
      end

      // Drop valid, wait out every response, then let the block go quiet.
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d requests over %0d capacity writes, list depth up to %0d.",
               requests_sent, cap_writes, deepest_list);
      $display("Responses: %0d ok, %0d full, %0d out of range; %0d mismatches.",
               ok_seen, full_seen, range_seen, error_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Response side: random back-pressure bursts, one long hold-off once the
   // block has some traffic behind it, and none in the quiet tail.
   initial begin
      int  hold_left;
      bit  long_hold_done;
      hold_left      = 0;
      long_hold_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!long_hold_done && results_seen >= HOLD_TRIGGER && req_chan.valid) begin
            // The sender keeps offering meanwhile, so the block fills and
            // stops taking requests.
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!quiet_tail && !rsp_calm && $urandom_range(0, 5) == 0) begin
            hold_left      = $urandom_range(1, 4) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Score each accepted response against the oldest pending prediction.
   always @(posedge clock) begin
      list_result want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         case (rsp_chan.status)
            STAT_OK:    ok_seen++;
            STAT_FULL:  full_seen++;
            STAT_RANGE: range_seen++;
            default:    ;
         endcase
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response: rd=%08h status=%0d count=%0d",
                                      rsp_chan.read_value, rsp_chan.status,
                                      rsp_chan.count));
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.read_value !== want.read_value ||
                rsp_chan.status !== want.status ||
                rsp_chan.count !== want.count) begin
               report_mismatch($sformatf(
                  {"response %0d: expected rd=%08h status=%0d count=%0d, ",
                   "got rd=%08h status=%0d count=%0d"},
                  results_seen, want.read_value, want.status, want.count,
                  rsp_chan.read_value, rsp_chan.status, rsp_chan.count));
            end
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d responses pending.",
                     stall_cycles, pending_results.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule
`default_nettype wire
